>>> rtl/core/cjs_pkg.sv
// Shared constants and types for the CPU job scheduler.
`default_nettype none
package cjs_pkg;
	localparam int MAX_JOBS_DEF = 64;
	localparam logic [1:0] MODE_RR = 2'd0;
	localparam logic [1:0] MODE_SJF = 2'd1;
	localparam logic [1:0] MODE_PRI = 2'd2;
	localparam logic [1:0] MODE_PRP = 2'd3;
	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_QUANTUM = 1'b1;
	localparam logic [23:0] CLOCK_MAX = 24'hFFFFFF;
	localparam logic [10:0] MARK_IDLE = 11'h400;
	localparam logic [10:0] MARK_NONE = 11'h7FF;
	typedef struct packed {
		logic [9:0] id;
		logic [15:0] arr;
		logic [15:0] burst;
		logic [7:0] prio;
	} job_t;
endpackage
`default_nettype wire

>>> rtl/core/cpu_job_scheduler_unit.sv
// Top level of the CPU job scheduler with its table sequencer.
//
// Channel  | Signals                                    | Direction
// in       | in_valid/in_ready, action..job_priority    | to block
// out      | out_valid/out_ready, dispatch_time..total  | from block
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data   | to block
//
// A load transaction writes one table slot in the load state. A step transaction reads table
// slots in turn through a read state and a check state: one selection scan in the other
// modes, or an admission scan before and after the run in round robin mode. A step with
// nothing to do goes straight to the output state.
// Reset clears the counters, queue pointers and clock; tables need no clearing.
// The block accepts no input or register write while a result waits on the output channel.
`default_nettype none
module cpu_job_scheduler_unit #(
	parameter int MAX_JOBS = cjs_pkg::MAX_JOBS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic action,
	input wire logic [9:0] job_id,
	input wire logic [15:0] arrival_time,
	input wire logic [15:0] burst_length,
	input wire logic [7:0] job_priority,
	output logic out_valid,
	input wire logic out_ready,
	output logic [23:0] dispatch_time,
	output logic [9:0] running_job,
	output logic idle_tick,
	output logic new_dispatch,
	output logic job_finished,
	output logic all_done,
	output logic [31:0] total_wait,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [3:0] cfg_data
);
	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_JOBS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ADM_RD = 4'd1;
	localparam logic [3:0] S_ADM_CHK = 4'd2;
	localparam logic [3:0] S_SEL_RD = 4'd3;
	localparam logic [3:0] S_SEL_CHK = 4'd4;
	localparam logic [3:0] S_POP = 4'd5;
	localparam logic [3:0] S_RUN_RD = 4'd6;
	localparam logic [3:0] S_RUN = 4'd7;
	localparam logic [3:0] S_FIN = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;
	localparam logic [3:0] S_LOAD = 4'd10;
	localparam logic [3:0] S_QRD = 4'd11;

	cjs_pkg::job_t job_mem [MAX_JOBS];
	logic [15:0] rem_mem [MAX_JOBS];
	logic adm_mem [MAX_JOBS];
	logic [AW-1:0] q_mem [MAX_JOBS];

	logic [3:0] state_q;
	logic [1:0] mode_q;
	logic [3:0] quantum_q;
	logic [CW-1:0] n_jobs_q, n_done_q, q_len_q;
	logic [AW-1:0] q_head_q, q_tail_q;
	logic [23:0] clock_q, t0_q;
	logic [31:0] wait_q;
	logic [10:0] prev_q;
	logic [AW-1:0] idx_q, sel_q;
	logic have_q, after_q, fin_q;
	logic [CW-1:0] cnt_q;
	cjs_pkg::job_t rd_job_q, sel_job_q, ld_q;
	logic [15:0] rd_rem_q, sel_rem_q;
	logic rd_adm_q;
	logic [AW-1:0] q_rd_q;
	logic [15:0] run_q;

	logic [23:0] o_time_q;
	logic [9:0] o_job_q;
	logic o_idle_q, o_new_q, o_fin_q, o_all_q;
	logic [31:0] o_wait_q;

	logic [AW-1:0] rd_addr;
	logic [15:0] key_i, key_s;
	logic better, eligible;
	logic [24:0] clk_sum;
	logic [16:0] need;
	logic [24:0] diff;
	logic [32:0] wsum;
	logic [3:0] qeff;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign cfg_ready = (state_q == S_IDLE) && !out_valid && !in_valid;

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_POP) begin
			rd_addr = q_rd_q;
		end else if (state_q == S_SEL_RD && cnt_q >= n_jobs_q) begin
			rd_addr = sel_q;
		end
	end

	assign eligible = (rd_rem_q != 16'd0) && ({8'd0, rd_job_q.arr} <= clock_q);
	assign key_i = (mode_q == cjs_pkg::MODE_SJF) ? rd_job_q.burst : {8'd0, rd_job_q.prio};
	assign key_s = (mode_q == cjs_pkg::MODE_SJF) ? sel_job_q.burst : {8'd0, sel_job_q.prio};
	assign better = (key_i < key_s) || (key_i == key_s && rd_job_q.arr < sel_job_q.arr);
	assign clk_sum = {1'b0, clock_q} + {9'd0, run_q};
	assign need = {1'b0, sel_job_q.arr} + {1'b0, sel_job_q.burst};
	assign diff = {1'b0, clock_q} - {8'd0, need};
	assign wsum = {1'b0, wait_q} + {9'd0, diff[23:0]};
	assign qeff = (quantum_q == 4'd0) ? 4'd1 : quantum_q;

	always_ff @(posedge clk) begin
		rd_job_q <= job_mem[rd_addr];
		rd_rem_q <= rem_mem[rd_addr];
		rd_adm_q <= adm_mem[rd_addr];
		q_rd_q <= q_mem[q_head_q];
		if (state_q == S_LOAD) begin
			job_mem[n_jobs_q[AW-1:0]] <= ld_q;
			rem_mem[n_jobs_q[AW-1:0]] <= ld_q.burst;
			adm_mem[n_jobs_q[AW-1:0]] <= 1'b0;
		end
		if (state_q == S_ADM_CHK && !rd_adm_q && eligible) begin
			adm_mem[idx_q] <= 1'b1;
			if (q_len_q < FULL) begin
				q_mem[q_tail_q] <= idx_q;
			end
		end
		if (state_q == S_SEL_CHK) begin
			adm_mem[idx_q] <= 1'b0;
		end
		if (state_q == S_RUN) begin
			rem_mem[sel_q] <= sel_rem_q - run_q;
		end
		if (state_q == S_FIN && after_q && mode_q == cjs_pkg::MODE_RR && have_q
				&& sel_rem_q != 16'd0 && q_len_q < FULL) begin
			q_mem[q_tail_q] <= sel_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= cjs_pkg::MODE_RR;
			quantum_q <= 4'd1;
			n_jobs_q <= '0;
			n_done_q <= '0;
			q_len_q <= '0;
			q_head_q <= '0;
			q_tail_q <= '0;
			clock_q <= '0;
			t0_q <= '0;
			wait_q <= '0;
			prev_q <= cjs_pkg::MARK_NONE;
			out_valid <= 1'b0;
			idx_q <= '0;
			sel_q <= '0;
			have_q <= 1'b0;
			after_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
			ld_q <= '0;
			sel_job_q <= '0;
			sel_rem_q <= '0;
			run_q <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cjs_pkg::CFG_MODE) begin
					mode_q <= cfg_data[1:0];
				end else begin
					quantum_q <= cfg_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						idx_q <= '0;
						cnt_q <= '0;
						have_q <= 1'b0;
						after_q <= 1'b0;
						fin_q <= 1'b0;
						t0_q <= clock_q;
						ld_q <= '{id: job_id, arr: arrival_time,
							burst: (burst_length == 16'd0) ? 16'd1 : burst_length,
							prio: job_priority};
						if (!action) begin
							state_q <= (n_jobs_q < FULL) ? S_LOAD : S_IDLE;
						end else if (n_done_q >= n_jobs_q) begin
							state_q <= S_OUT;
						end else if (mode_q == cjs_pkg::MODE_RR) begin
							state_q <= S_ADM_RD;
						end else begin
							q_len_q <= '0;
							q_head_q <= '0;
							q_tail_q <= '0;
							state_q <= S_SEL_RD;
						end
					end
				end
				S_LOAD: begin
					n_jobs_q <= n_jobs_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_ADM_RD: begin
					state_q <= (cnt_q < n_jobs_q) ? S_ADM_CHK : (after_q ? S_FIN : S_QRD);
				end
				S_ADM_CHK: begin
					if (!rd_adm_q && eligible && q_len_q < FULL) begin
						q_tail_q <= (q_tail_q == AW'(MAX_JOBS - 1)) ? '0 : q_tail_q + 1'b1;
						q_len_q <= q_len_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_ADM_RD;
				end
				S_QRD: begin
					state_q <= S_POP;
				end
				S_POP: begin
					if (q_len_q != '0) begin
						sel_q <= q_rd_q;
						have_q <= 1'b1;
						q_head_q <= (q_head_q == AW'(MAX_JOBS - 1)) ? '0 : q_head_q + 1'b1;
						q_len_q <= q_len_q - 1'b1;
						state_q <= S_RUN_RD;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN_RD: begin
					state_q <= S_RUN;
				end
				S_SEL_RD: begin
					state_q <= (cnt_q < n_jobs_q) ? S_SEL_CHK : S_RUN_RD;
					if (cnt_q >= n_jobs_q && !have_q) begin
						state_q <= S_RUN;
					end
				end
				S_SEL_CHK: begin
					if (eligible && (!have_q || better)) begin
						sel_q <= idx_q;
						have_q <= 1'b1;
						sel_job_q <= rd_job_q;
					end
					idx_q <= idx_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_SEL_RD;
				end
				S_RUN: begin
					if (have_q) begin
						clock_q <= (clk_sum > {1'b0, cjs_pkg::CLOCK_MAX}) ?
							cjs_pkg::CLOCK_MAX : clk_sum[23:0];
						fin_q <= (sel_rem_q == run_q);
						sel_rem_q <= sel_rem_q - run_q;
					end else begin
						clock_q <= (clock_q == cjs_pkg::CLOCK_MAX) ? clock_q : clock_q + 1'b1;
					end
					after_q <= 1'b1;
					idx_q <= '0;
					cnt_q <= '0;
					state_q <= (mode_q == cjs_pkg::MODE_RR) ? S_ADM_RD : S_FIN;
				end
				S_FIN: begin
					if (have_q && fin_q) begin
						n_done_q <= n_done_q + 1'b1;
						if ({1'b0, clock_q} > {8'd0, need}) begin
							wait_q <= wsum[32] ? 32'hFFFFFFFF : wsum[31:0];
						end
					end
					if (mode_q == cjs_pkg::MODE_RR && have_q && sel_rem_q != 16'd0
							&& q_len_q < FULL) begin
						q_tail_q <= (q_tail_q == AW'(MAX_JOBS - 1)) ? '0 : q_tail_q + 1'b1;
						q_len_q <= q_len_q + 1'b1;
					end
					prev_q <= have_q ? {{(11-AW){1'b0}}, sel_q} : cjs_pkg::MARK_IDLE;
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_RUN_RD) begin
				sel_job_q <= rd_job_q;
				sel_rem_q <= rd_rem_q;
				if (mode_q == cjs_pkg::MODE_RR) begin
					run_q <= (rd_rem_q < {12'd0, qeff}) ? rd_rem_q : {12'd0, qeff};
				end else if (mode_q == cjs_pkg::MODE_PRP) begin
					run_q <= 16'd1;
				end else begin
					run_q <= rd_rem_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			o_time_q <= t0_q;
			o_job_q <= have_q ? sel_job_q.id : 10'd0;
			o_idle_q <= !have_q;
			o_new_q <= have_q ? (prev_q != {{(11-AW){1'b0}}, sel_q})
				: (prev_q != cjs_pkg::MARK_IDLE);
			o_fin_q <= have_q && fin_q;
			o_all_q <= ((have_q && fin_q) ? n_done_q + 1'b1 : n_done_q) >= n_jobs_q;
		end else if (state_q == S_IDLE && in_valid && in_ready && action
				&& n_done_q >= n_jobs_q) begin
			o_time_q <= clock_q;
			o_job_q <= '0;
			o_idle_q <= 1'b0;
			o_new_q <= 1'b0;
			o_fin_q <= 1'b0;
			o_all_q <= 1'b1;
		end
	end

	assign dispatch_time = o_time_q;
	assign running_job = o_job_q;
	assign idle_tick = o_idle_q;
	assign new_dispatch = o_new_q;
	assign job_finished = o_fin_q;
	assign all_done = o_all_q;
	assign total_wait = o_all_q ? wait_q : 32'd0;

	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_qlen: assert property (@(posedge clk) disable iff (!arst_n)
		q_len_q <= FULL) else $error("queue overflow");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		n_done_q <= n_jobs_q) else $error("done count beyond job count");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid) else $error("result not shown");
endmodule
`default_nettype wire

>>> bench/cpu_job_scheduler_unit_tb.sv
// Self-checking testbench for the CPU job scheduler: directed and random jobs in all four modes.
module cpu_job_scheduler_unit_tb;
	localparam int JOBS = cjs_pkg::MAX_JOBS_DEF;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [23:0] t;
		logic [9:0] job;
		logic idle;
		logic newd;
		logic fin;
		logic done;
		logic [31:0] wait_total;
	} dispatch_t;

	class sched_scoreboard;
		cjs_pkg::job_t tbl[JOBS];
		logic [15:0] remain[JOBS];
		bit admitted[JOBS];
		int unsigned rq[JOBS];
		int unsigned qh, qt, ql;
		int unsigned clk_now, njobs, ndone, prev, quantum;
		longint unsigned wsum;
		logic [1:0] mode;
		dispatch_t expq[$];
		int errors;

		function new();
			qh = 0; qt = 0; ql = 0; clk_now = 0; njobs = 0; ndone = 0;
			wsum = 0; prev = cjs_pkg::MARK_NONE; mode = cjs_pkg::MODE_RR; quantum = 1;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [3:0] val);
			if (idx == cjs_pkg::CFG_MODE) mode = val[1:0];
			else quantum = val;
		endfunction

		function void advance(int unsigned d);
			clk_now = (clk_now + d > cjs_pkg::CLOCK_MAX) ? cjs_pkg::CLOCK_MAX : clk_now + d;
		endfunction

		function void push_slot(int unsigned s);
			if (ql < JOBS) begin
				rq[qt] = s;
				qt = (qt + 1) % JOBS;
				ql++;
			end
		endfunction

		function void admit_arrivals();
			for (int i = 0; i < njobs; i++) begin
				if (!admitted[i] && remain[i] > 0 && tbl[i].arr <= clk_now) begin
					push_slot(i);
					admitted[i] = 1;
				end
			end
		endfunction

		function void note_input(logic act, cjs_pkg::job_t j);
			dispatch_t r;
			int sel;
			int unsigned t0, run, q, k, kb, need;
			t0 = clk_now;
			sel = -1;
			run = 0;
			if (!act) begin
				if (njobs < JOBS) begin
					tbl[njobs] = j;
					if (j.burst == 0) tbl[njobs].burst = 16'd1;
					remain[njobs] = tbl[njobs].burst;
					admitted[njobs] = 0;
					njobs++;
				end
				return;
			end
			r = '0;
			r.t = t0[23:0];
			if (ndone >= njobs) begin
				r.done = 1;
				r.wait_total = wsum[31:0];
				expq.push_back(r);
				return;
			end
			if (mode == cjs_pkg::MODE_RR) begin
				admit_arrivals();
				if (ql > 0) begin
					sel = rq[qh];
					qh = (qh + 1) % JOBS;
					ql--;
					q = (quantum != 0) ? quantum : 1;
					run = (remain[sel] < q) ? remain[sel] : q;
				end
			end else begin
				qh = 0; qt = 0; ql = 0;
				for (int i = 0; i < JOBS; i++) admitted[i] = 0;
				for (int i = 0; i < njobs; i++) begin
					if (remain[i] == 0 || tbl[i].arr > clk_now) continue;
					if (sel < 0) begin
						sel = i;
						continue;
					end
					k = (mode == cjs_pkg::MODE_SJF) ? tbl[i].burst : tbl[i].prio;
					kb = (mode == cjs_pkg::MODE_SJF) ? tbl[sel].burst : tbl[sel].prio;
					if (k < kb || (k == kb && tbl[i].arr < tbl[sel].arr)) sel = i;
				end
				if (sel >= 0) run = (mode == cjs_pkg::MODE_PRP) ? 1 : remain[sel];
			end
			if (sel < 0) begin
				advance(1);
				if (mode == cjs_pkg::MODE_RR) admit_arrivals();
				r.idle = 1;
				r.newd = (prev != cjs_pkg::MARK_IDLE);
				prev = cjs_pkg::MARK_IDLE;
			end else begin
				remain[sel] = 16'(remain[sel] - run);
				advance(run);
				if (remain[sel] == 0) begin
					need = tbl[sel].arr + tbl[sel].burst;
					ndone++;
					if (clk_now > need) begin
						wsum += clk_now - need;
						if (wsum > 64'hFFFFFFFF) wsum = 64'hFFFFFFFF;
					end
					r.fin = 1;
				end
				if (mode == cjs_pkg::MODE_RR) begin
					admit_arrivals();
					if (remain[sel] > 0) push_slot(sel);
				end
				r.job = tbl[sel].id;
				r.newd = (prev != sel);
				prev = sel;
			end
			r.done = (ndone >= njobs);
			r.wait_total = r.done ? wsum[31:0] : 32'd0;
			expq.push_back(r);
		endfunction

		function void check_result(dispatch_t got);
			dispatch_t e;
			if (expq.size() == 0) begin
				if (errors < 10) $display("Unexpected result transaction: %p", got);
				errors++;
				return;
			end
			e = expq.pop_front();
			if (got.t !== e.t || got.job !== e.job || got.idle !== e.idle
					|| got.newd !== e.newd || got.fin !== e.fin || got.done !== e.done
					|| got.wait_total !== e.wait_total) begin
				if (errors < 10) $display("Mismatch: expected %p, got %p", e, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, action = 0;
	logic [9:0] job_id = 0;
	logic [15:0] arrival_time = 0, burst_length = 0;
	logic [7:0] job_priority = 0;
	logic out_ready = 0;
	logic cfg_valid = 0, cfg_index = 0;
	logic [3:0] cfg_data = 0;
	logic in_ready, out_valid, cfg_ready;
	logic [23:0] dispatch_time;
	logic [9:0] running_job;
	logic idle_tick, new_dispatch, job_finished, all_done;
	logic [31:0] total_wait;

	sched_scoreboard sb = new();
	int items = 0;
	int stage = 0;
	int stall_cycles = 0;

	cpu_job_scheduler_unit DUT (.*);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		case (stage)
			0: out_ready = ($urandom_range(0, 99) >= 56);
			1: out_ready = ($urandom_range(0, 99) >= 21);
			default: out_ready = 1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({dispatch_time, running_job, idle_tick, new_dispatch,
				job_finished, all_done, total_wait});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_item(logic act, logic [9:0] id, logic [15:0] a, logic [15:0] b,
			logic [7:0] p);
		cjs_pkg::job_t j;
		int rate;
		rate = (stage == 0) ? 21 : (stage == 1) ? 56 : 0;
		while ($urandom_range(0, 99) < rate) @(negedge clk);
		j = '{id: id, arr: a, burst: b, prio: p};
		if (act || sb.njobs < JOBS) items++;
		stage = (items < 217) ? 0 : (items < 434) ? 1 : 2;
		action = act; job_id = id; arrival_time = a; burst_length = b; job_priority = p;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(act, j);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic load_job(logic [9:0] id, logic [15:0] a, logic [15:0] b, logic [7:0] p);
		send_item(1'b0, id, a, b, p);
	endtask

	task automatic step_sched(int n);
		repeat (n) send_item(1'b1, 10'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom));
	endtask

	task automatic drain();
		while (sb.expq.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [3:0] val);
		cfg_index = idx; cfg_data = val; cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_mode(logic [1:0] m, logic [3:0] q);
		drain();
		write_cfg(cjs_pkg::CFG_MODE, {2'b00, m});
		write_cfg(cjs_pkg::CFG_QUANTUM, q);
	endtask

	initial begin
		logic [1:0] m;
		int k;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		set_mode(cjs_pkg::MODE_SJF, 4'd0);
		step_sched(1);
		load_job(10'd1023, 16'hFFFF, 16'hFFFF, 8'd255);
		load_job(10'd0, 16'd0, 16'd0, 8'd0);
		load_job(10'd5, 16'd0, 16'hFFFF, 8'd0);
		step_sched(4);
		set_mode(cjs_pkg::MODE_RR, 4'd0);
		load_job(10'd5, 16'd4, 16'd3, 8'd1);
		load_job(10'd7, 16'd4, 16'd2, 8'd2);
		step_sched(4);
		set_mode(cjs_pkg::MODE_PRP, 4'd15);
		load_job(10'd9, 16'd0, 16'd2, 8'd200);
		load_job(10'd10, 16'd0, 16'd1, 8'd3);
		step_sched(4);
		set_mode(cjs_pkg::MODE_PRI, 4'd9);
		load_job(10'd11, 16'd0, 16'd4, 8'd7);
		load_job(10'd12, 16'd0, 16'd4, 8'd7);
		step_sched(3);

		while (items < 650) begin
			m = 2'($urandom_range(0, 3));
			set_mode(m, ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 9)));
			k = $urandom_range(0, 6);
			repeat (k) begin
				if (m == cjs_pkg::MODE_SJF || m == cjs_pkg::MODE_PRI)
					load_job(10'($urandom), 16'($urandom), ($urandom_range(0, 9) == 0)
						? 16'($urandom) : 16'($urandom_range(0, 30)), 8'($urandom));
				else
					load_job(10'($urandom), 16'($urandom), 16'($urandom_range(0, 12)),
						8'($urandom));
			end
			if (m == cjs_pkg::MODE_SJF || m == cjs_pkg::MODE_PRI)
				step_sched(int'(sb.njobs - sb.ndone + $urandom_range(0, 3)));
			else
				step_sched(int'($urandom_range(5, 40)));
		end

		drain();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/cjs_pkg.sv
rtl/core/cpu_job_scheduler_unit.sv
bench/cpu_job_scheduler_unit_tb.sv
